// File: rtl/core/spm_pkg.sv
// spm_pkg: shared sizes, codes and word types of the sparse paged memory.
// Depends on nothing; every module of the block but spm_ram imports it.
package spm_pkg;

  localparam int MAX_PAGES      = 16;
  localparam int PAGE_BYTES     = 4096;
  localparam int ADDR_BITS      = 64;
  localparam int DATA_BITS      = 64;
  localparam int OFF_BITS       = $clog2(PAGE_BYTES);
  localparam int PN_BITS        = ADDR_BITS - OFF_BITS;
  localparam int WORDS_PER_PAGE = PAGE_BYTES / 8;
  localparam int WORD_BITS      = $clog2(WORDS_PER_PAGE);
  localparam int FRAME_BITS     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int COUNT_BITS     = $clog2(MAX_PAGES + 1);
  localparam int TOTAL_WORDS    = MAX_PAGES * WORDS_PER_PAGE;
  localparam int MEM_ABITS      = FRAME_BITS + WORD_BITS;
  localparam int QDEPTH         = 2;
  localparam int QPTR_BITS      = 1;
  localparam int QCNT_BITS      = 2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [ADDR_BITS-1:0] address;
    logic [1:0]           size_log2;
    logic [DATA_BITS-1:0] write_data;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 page_created;
    logic                 table_full;
  } mem_rsp_t;

  // one classified access waiting for the frame memory
  typedef struct packed {
    logic                  is_write;
    logic                  has_frame;
    logic                  created;
    logic                  full;
    logic [FRAME_BITS-1:0] frame;
    logic [WORD_BITS-1:0]  word;
    logic [2:0]            lane;
    logic [1:0]            size_log2;
    logic [DATA_BITS-1:0]  wdata;
  } spm_op_t;

endpackage

// File: rtl/core/spm_ram.sv
// spm_ram: generic one-write, one-read RAM with registered read data.
// No package dependency.
module spm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/spm_front.sv
// spm_front: page table lookup, frame allocation and classification of words.
// Depends on spm_pkg.
module spm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  spm_pkg::mem_req_t request,
  output spm_pkg::spm_op_t  op
);
  import spm_pkg::*;

  logic [PN_BITS-1:0]    page_table [MAX_PAGES];
  logic [COUNT_BITS-1:0] pages_in_use;

  logic [PN_BITS-1:0]    pn;
  logic [OFF_BITS-1:0]   offset;
  logic [MAX_PAGES-1:0]  hit;
  logic [FRAME_BITS-1:0] hit_frame;
  logic                  mapped;
  logic                  alloc;
  logic                  is_write;

  always_comb begin
    pn       = request.address[ADDR_BITS-1:OFF_BITS];
    offset   = request.address[OFF_BITS-1:0] &
               ~((OFF_BITS'(1) << request.size_log2) - OFF_BITS'(1));
    is_write = (request.command == CMD_WRITE);
    for (int i = 0; i < MAX_PAGES; i++) begin
      hit[i] = (COUNT_BITS'(i) < pages_in_use) && (page_table[i] == pn);
    end
    hit_frame = '0;
    for (int i = MAX_PAGES - 1; i >= 0; i--) begin
      if (hit[i]) hit_frame = FRAME_BITS'(i);
    end
    mapped = |hit;
    alloc  = is_write && !mapped && (pages_in_use < COUNT_BITS'(MAX_PAGES));

    op.is_write  = is_write;
    op.has_frame = mapped || alloc;
    op.created   = alloc;
    op.full      = is_write && !mapped && !alloc;
    op.frame     = alloc ? pages_in_use[FRAME_BITS-1:0] : hit_frame;
    op.word      = offset[OFF_BITS-1:3];
    op.lane      = offset[2:0];
    op.size_log2 = request.size_log2;
    op.wdata     = request.write_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= '0;
    end else if (accept && alloc) begin
      pages_in_use <= pages_in_use + COUNT_BITS'(1);
    end
    if (accept && alloc) begin
      page_table[pages_in_use[FRAME_BITS-1:0]] <= pn;
    end
  end
endmodule

// File: rtl/core/spm_queue.sv
// spm_queue: short queue of classified words between front and back.
// Depends on spm_pkg.
module spm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spm_pkg::spm_op_t push_op,
  input  logic             pop,
  output logic             nonempty,
  output logic             full,
  output spm_pkg::spm_op_t head
);
  import spm_pkg::*;

  spm_op_t              slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign nonempty = (count != '0);
  assign full     = (count == QCNT_BITS'(QDEPTH));
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      count <= count + QCNT_BITS'(1);
      else if (pop && !push) count <= count - QCNT_BITS'(1);
    end
    if (push) slots[wr_ptr] <= push_op;
  end
endmodule

// File: rtl/core/spm_back.sv
// spm_back: frame clearing sweep and read-modify-write of the frame memory.
// Depends on spm_pkg and spm_ram.
module spm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  spm_pkg::spm_op_t  q_head,
  output logic              q_pop,
  output logic              done,
  output spm_pkg::mem_rsp_t result
);
  import spm_pkg::*;

  typedef enum logic [1:0] {IDLE, CLEAR, RD, RMW} state_t;

  state_t               state;
  spm_op_t              op;
  logic [WORD_BITS-1:0] clr_cnt;

  logic                 we;
  logic [MEM_ABITS-1:0] waddr;
  logic [MEM_ABITS-1:0] raddr;
  logic [DATA_BITS-1:0] wdata;
  logic [DATA_BITS-1:0] rdata;
  logic [7:0]           be;
  logic [DATA_BITS-1:0] bmask;
  logic [DATA_BITS-1:0] vmask;
  logic [5:0]           sh;
  logic [DATA_BITS-1:0] merged;

  spm_ram #(.WIDTH(DATA_BITS), .DEPTH(TOTAL_WORDS)) u_frames (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    q_pop = (state == IDLE) && q_nonempty;
    raddr = (state == RD) ? {op.frame, op.word} : {q_head.frame, q_head.word};
    sh    = {op.lane, 3'b000};
    be    = ((8'd1 << (4'd1 << op.size_log2)) - 8'd1) << op.lane;
    if (op.size_log2 == 2'd3) be = 8'hff;
    for (int b = 0; b < 8; b++) bmask[b*8 +: 8] = {8{be[b]}};
    vmask  = bmask >> sh;
    merged = (rdata & ~bmask) | ((op.wdata << sh) & bmask);
    we    = 1'b0;
    waddr = {op.frame, op.word};
    wdata = merged;
    if (state == CLEAR) begin
      we    = 1'b1;
      waddr = {op.frame, clr_cnt};
      wdata = '0;
    end else if (state == RMW && op.is_write && op.has_frame) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (q_nonempty) begin
            op      <= q_head;
            clr_cnt <= '0;
            state   <= q_head.created ? CLEAR : RMW;
          end
        end
        CLEAR: begin
          clr_cnt <= clr_cnt + WORD_BITS'(1);
          if (clr_cnt == {WORD_BITS{1'b1}}) state <= RD;
        end
        RD: state <= RMW;
        RMW: begin
          done                <= 1'b1;
          result.read_data    <= (!op.is_write && op.has_frame) ? ((rdata >> sh) & vmask) : '0;
          result.page_created <= op.created;
          result.table_full   <= op.full;
          state               <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/sparse_paged_memory.sv
// sparse_paged_memory: top level of the sparse page-mapped memory.
// Depends on spm_pkg, spm_front, spm_queue, spm_back, spm_ram.
//
//  channel   | ports                    | handshake
//  ----------+--------------------------+--------------------------------
//  request   | start, busy, request     | word taken when start & !busy
//  result    | done, result             | one-cycle strobe, no stall
//
// In the back end a hit or miss-read goes through the queue pop with the
// frame RAM read, then the read-modify-write state. A write that allocates a
// frame adds a clearing sweep over all WORDS_PER_PAGE words (512) through
// the single write port of the frame RAM, then a read state.
// Reset clears the page count, the queue and the back-end state; frame
// contents need none since every frame is swept to zero when allocated.
// busy rises only when the two-entry queue is full; results cannot be held.
module sparse_paged_memory (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spm_pkg::mem_req_t request,
  output logic              done,
  output spm_pkg::mem_rsp_t result
);
  import spm_pkg::*;

  spm_op_t front_op;
  spm_op_t q_head;
  logic    accept;
  logic    q_full;
  logic    q_nonempty;
  logic    q_pop;

  assign busy   = q_full;
  assign accept = start && !busy;

  // lookup and allocation happen at accept, so a following word sees the
  // updated table at once
  spm_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .request(request), .op(front_op)
  );

  spm_queue u_queue (
    .clk(clk), .rst(rst), .push(accept), .push_op(front_op), .pop(q_pop),
    .nonempty(q_nonempty), .full(q_full), .head(q_head)
  );

  spm_back u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_nonempty), .q_head(q_head),
    .q_pop(q_pop), .done(done), .result(result)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full && !q_pop |=> q_full || !accept || $past(q_pop))
    else $error("queue overflow");
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back result strobes");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.page_created && result.table_full))
    else $error("created and full together");
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.table_full |-> result.read_data == '0)
    else $error("dropped write returned data");
`endif
endmodule

// File: verif/testbench.sv
// testbench: drives access words into sparse_paged_memory and checks every
// result against an in-bench model of the paged store. Depends on spm_pkg and sparse_paged_memory.
`timescale 1ns / 100ps

module testbench;
  import spm_pkg::*;

  // scoreboard: own copy of the page table and frames, queue of predictions
  class access_board;
    logic [PN_BITS-1:0]   page_no_q[MAX_PAGES];
    int                   mapped_count;
    logic [DATA_BITS-1:0] frames[TOTAL_WORDS];
    mem_rsp_t             pending[$];
    int                   errors;
    int                   checked;
    int                   created_seen;
    int                   full_seen;

    function void clear();
      mapped_count = 0;
      pending.delete();
      errors = 0;
      checked = 0;
      created_seen = 0;
      full_seen = 0;
    endfunction

    // work out the result of one accepted access and update the store
    function void note_access(mem_req_t rq);
      logic [PN_BITS-1:0]   pn;
      logic [OFF_BITS-1:0]  off;
      logic [DATA_BITS-1:0] mask;
      logic [DATA_BITS-1:0] word;
      int                   frame;
      int                   shift;
      int                   widx;
      mem_rsp_t             rs;
      pn = rq.address[ADDR_BITS-1:OFF_BITS];
      off = rq.address[OFF_BITS-1:0] &
            ~((OFF_BITS'(1) << rq.size_log2) - OFF_BITS'(1));
      mask = (rq.size_log2 == 2'd3) ? '1 : ((64'd1 << (8 << rq.size_log2)) - 64'd1);
      shift = off[2:0] * 8;
      rs = '0;
      frame = -1;
      for (int i = 0; i < mapped_count; i++)
        if (page_no_q[i] == pn) frame = i;
      if (rq.command == CMD_WRITE && frame < 0) begin
        if (mapped_count < MAX_PAGES) begin
          frame = mapped_count;
          page_no_q[frame] = pn;
          for (int w = 0; w < WORDS_PER_PAGE; w++)
            frames[frame * WORDS_PER_PAGE + w] = '0;
          mapped_count++;
          rs.page_created = 1'b1;
        end else begin
          rs.table_full = 1'b1;
        end
      end
      if (frame >= 0) begin
        widx = frame * WORDS_PER_PAGE + off[OFF_BITS-1:3];
        word = frames[widx];
        if (rq.command == CMD_WRITE)
          frames[widx] = (word & ~(mask << shift)) | ((rq.write_data & mask) << shift);
        else
          rs.read_data = (word >> shift) & mask;
      end
      pending.push_back(rs);
    endfunction

    task check_result(mem_rsp_t got);
      mem_rsp_t exp_rs;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 0, got.read_data);
        return;
      end
      exp_rs = pending.pop_front();
      checked++;
      if (got.page_created) created_seen++;
      if (got.table_full) full_seen++;
      if (got.read_data !== exp_rs.read_data)
        report_mismatch("read_data", exp_rs.read_data, got.read_data);
      if (got.page_created !== exp_rs.page_created)
        report_mismatch("page_created", exp_rs.page_created, got.page_created);
      if (got.table_full !== exp_rs.table_full)
        report_mismatch("table_full", exp_rs.table_full, got.table_full);
    endtask

    task report_mismatch(string what, logic [63:0] e, logic [63:0] g);
      errors++;
      $display("mismatch %s: expected %h got %h", what, e, g);
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  mem_req_t request;
  logic     done;
  mem_rsp_t result;

  access_board board;
  logic [PN_BITS-1:0] used_pages[$];

  sparse_paged_memory u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // results cannot be stalled: check on every strobe
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // send one access word; holds start until accepted, then may idle for a random gap
  task automatic send_word(logic cmd, logic [63:0] addr, logic [1:0] sz,
                           logic [63:0] wd);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    start <= 1'b1;
    request <= '{command: cmd, address: addr, size_log2: sz, write_data: wd};
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_access('{command: cmd, address: addr, size_log2: sz, write_data: wd});
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // address in a page seen before (most of the time) or a fresh one
  function automatic logic [63:0] pick_addr();
    logic [PN_BITS-1:0] pn;
    if (used_pages.size() > 0 && $urandom_range(0, 9) < 8)
      pn = used_pages[$urandom_range(0, used_pages.size() - 1)];
    else begin
      pn = PN_BITS'(rand64() >> OFF_BITS);
      if (used_pages.size() < 24) used_pages.push_back(pn);
    end
    return {pn, OFF_BITS'($urandom())};
  endfunction

  initial begin
    int wait_cycles;
    board = new();
    board.clear();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unmapped read, allocate, every size, misalignment, extremes
    send_word(CMD_READ, 64'h0, 2'd3, 64'h0);
    send_word(CMD_WRITE, 64'h0, 2'd3, '1);
    send_word(CMD_READ, 64'h0, 2'd3, 64'h0);
    send_word(CMD_WRITE, 64'h3, 2'd0, 64'hA5);
    send_word(CMD_READ, 64'h3, 2'd0, 64'h0);
    send_word(CMD_WRITE, 64'h5, 2'd1, 64'h1234_5678);
    send_word(CMD_READ, 64'h4, 2'd1, 64'h0);
    send_word(CMD_WRITE, 64'h7, 2'd2, 64'hDEAD_BEEF_CAFE_F00D);
    send_word(CMD_READ, 64'h4, 2'd2, 64'h0);
    send_word(CMD_READ, 64'h1, 2'd3, 64'h0);
    send_word(CMD_WRITE, '1, 2'd3, 64'h0123_4567_89AB_CDEF);
    send_word(CMD_READ, '1, 2'd0, '1);
    send_word(CMD_READ, 64'hFFFF_FFFF_FFFF_F000, 2'd3, 64'h0);
    send_word(CMD_WRITE, 64'h0000_0000_0000_1FFF, 2'd0, '1);
    send_word(CMD_READ, 64'h0000_0000_0000_1800, 2'd3, 64'h0);
    send_word(CMD_READ, 64'h8000_0000_0000_0000, 2'd3, 64'h0);
    // fill the table, then write to yet another page
    for (int p = 0; p < MAX_PAGES; p++)
      send_word(CMD_WRITE, {52'(p + 64'h100), 12'h008}, 2'd2, rand64());
    send_word(CMD_WRITE, 64'h7777_0000, 2'd3, rand64());
    send_word(CMD_READ, 64'h7777_0000, 2'd3, 64'h0);
    while (board.pending.size() > 0) @(posedge clk);

    // random: table is full, so reads and writes of mapped pages dominate;
    // seed the page pool with the mapped pages; fresh pages join it later
    for (int i = 0; i < board.mapped_count; i++) used_pages.push_back(board.page_no_q[i]);
    for (int n = 0; n < 1200; n++)
      send_word($urandom_range(0, 1), pick_addr(), $urandom_range(0, 3), rand64());
    start <= 1'b0;

    wait_cycles = 0;
    while (board.pending.size() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (1100) @(posedge clk);
    $display("checked %0d results: %0d page allocations, %0d full-table writes",
             board.checked, board.created_seen, board.full_seen);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // allocations are the slow accesses, since each sweeps a whole frame clear
  initial begin
    #5ms;
    $display("testbench: timeout");
    $display("testbench: done, errors");
    $finish;
  end
endmodule
